FILE: rtl/core/infl_pkg.sv
// ----------------------------------------------------------------------------
// infl_pkg
// Shared widths, operation codes, status codes and register indexes for the
// object-number free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package infl_pkg;

  // field widths
  localparam int OP_W        = 3;
  localparam int NUM_W       = 10;
  localparam int ADDR_W      = 48;
  localparam int COUNT_W     = 11;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;

  typedef logic [OP_W-1:0]        op_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // operation codes
  localparam op_t OP_FORMAT         = 3'd0;
  localparam op_t OP_RECOVERY_START = 3'd1;
  localparam op_t OP_RECOVERY_MARK  = 3'd2;
  localparam op_t OP_RECOVERY_END   = 3'd3;
  localparam op_t OP_ALLOCATE       = 3'd4;
  localparam op_t OP_RELEASE        = 3'd5;
  localparam op_t OP_SET_ADDRESS    = 3'd6;
  localparam op_t OP_GET_ADDRESS    = 3'd7;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // configuration register indexes
  localparam cfg_index_t CFG_BASE_ADDRESS = 1'd0;
  localparam cfg_index_t CFG_ENTRY_COUNT  = 1'd1;

  // entry count reset value and lower limit
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MIN         = 11'd2;

endpackage : infl_pkg

`default_nettype wire

FILE: rtl/core/inode_number_free_list_core.sv
// ----------------------------------------------------------------------------
// inode_number_free_list_core
// Object-number allocator: free numbers form a fifo linked list in a link
// memory; a second memory holds the per-number address and in-use mark.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+-----------------
//  command   | op, number, address_value                     | start & !busy
//  result    | status, allocated_number, address_out,        | done (one cycle)
//            | already_marked, write_valid, write_address,   |
//            | write_data                                    |
//  config    | cfg_index, cfg_data                           | cfg_write
//
//  release, out-of-range, empty allocate, allocate of the last entry and format
//  with a count of two complete from the idle state; allocate, mark, set and get
//  address read a memory, then do the update; format and recovery end do one
//  link write or mark read per cycle; recovery start runs the mark clearing pass
//  over every entry. reset starts the same clearing pass: busy stays high to its end.
//  the result receiver cannot stall; done pulses for one cycle per transaction.
//
`default_nettype none

module inode_number_free_list_core #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // command
  input  wire logic                           start,
  output logic                                busy,
  input  wire infl_pkg::op_t                  op,
  input  wire logic [infl_pkg::NUM_W-1:0]     number,
  input  wire logic [infl_pkg::ADDR_W-1:0]    address_value,
  // result
  output logic                                done,
  output infl_pkg::status_t                   status,
  output logic [infl_pkg::NUM_W-1:0]          allocated_number,
  output logic [infl_pkg::ADDR_W-1:0]         address_out,
  output logic                                already_marked,
  output logic                                write_valid,
  output logic [infl_pkg::ADDR_W-1:0]         write_address,
  output logic [infl_pkg::ADDR_W-1:0]         write_data,
  // configuration
  input  wire logic                           cfg_write,
  input  wire infl_pkg::cfg_index_t           cfg_index,
  input  wire logic [infl_pkg::ADDR_W-1:0]    cfg_data
);

  localparam int IW       = $clog2(ENTRIES);
  localparam int WW       = ((IW > infl_pkg::COUNT_W) ? IW : infl_pkg::COUNT_W) + 1;
  localparam int MARK_BIT = infl_pkg::ADDR_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // state codes
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLEAR    = 3'd1;
  localparam logic [2:0] S_CLRTAIL  = 3'd2;
  localparam logic [2:0] S_FMT      = 3'd3;
  localparam logic [2:0] S_REND     = 3'd4;
  localparam logic [2:0] S_RENDTAIL = 3'd5;
  localparam logic [2:0] S_ALLOC    = 3'd6;
  localparam logic [2:0] S_AMEM     = 3'd7;

  // memories
  logic [IW-1:0]               link_mem [ENTRIES];
  logic [infl_pkg::ADDR_W:0]   addr_mem [ENTRIES];

  logic                        link_we;
  logic [IW-1:0]               link_waddr, link_wdata, link_raddr, link_rdata;
  logic                        addr_we;
  logic [IW-1:0]               addr_waddr, addr_raddr;
  logic [infl_pkg::ADDR_W:0]   addr_wdata, addr_rdata;

  // control registers
  logic [2:0]                  state, state_next;
  logic [IW-1:0]               scan, scan_next;
  logic                        pend, pend_next;
  logic [IW-1:0]               pidx, pidx_next;
  logic                        clr_reply, clr_reply_next;
  logic [IW-1:0]               head, head_next;
  logic [IW-1:0]               tail, tail_next;
  logic                        empty, empty_next;
  logic [infl_pkg::ADDR_W-1:0] base_address;
  logic [infl_pkg::COUNT_W-1:0] entry_count;

  // captured command
  infl_pkg::op_t               op_q;
  logic [IW-1:0]               num_q;
  logic [infl_pkg::NUM_W-1:0]  number_q;
  logic [infl_pkg::ADDR_W-1:0] aval_q;

  // result staging
  logic                        res_fire;
  infl_pkg::status_t           st_res;
  logic [infl_pkg::NUM_W-1:0]  alloc_res;
  logic [infl_pkg::ADDR_W-1:0] aout_res;
  logic                        marked_res;
  logic                        wvalid_res;
  logic [infl_pkg::ADDR_W-1:0] waddr_res;
  logic [infl_pkg::ADDR_W-1:0] wdata_res;

  // append helper
  logic                        app_en;
  logic [IW-1:0]               app_num;

  logic                        accept;
  logic [infl_pkg::COUNT_W-1:0] count_lim, eff_count;
  logic                        in_range;
  logic [IW-1:0]               num_idx;
  logic [WW-1:0]               count_w, scan_w;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // effective count and range check
  always_comb begin
    count_lim = (32'(entry_count) > 32'(ENTRIES)) ? infl_pkg::COUNT_W'(ENTRIES)
                                                  : entry_count;
    eff_count = (count_lim < infl_pkg::COUNT_MIN) ? infl_pkg::COUNT_MIN : count_lim;
  end

  assign in_range = ({1'b0, number} < eff_count);
  assign num_idx  = IW'(number);
  assign count_w  = WW'(eff_count);
  assign scan_w   = WW'(scan);

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

  // address and mark memory
  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[addr_waddr] <= addr_wdata;
    end
    addr_rdata <= addr_mem[addr_raddr];
  end

  // sequencer
  always_comb begin
    state_next     = state;
    scan_next      = scan;
    pend_next      = pend;
    pidx_next      = pidx;
    clr_reply_next = clr_reply;
    head_next      = head;
    tail_next      = tail;
    empty_next     = empty;

    link_we    = 1'b0;
    link_waddr = tail;
    link_wdata = scan + IW'(1);
    link_raddr = head;
    addr_we    = 1'b0;
    addr_waddr = pidx;
    addr_wdata = {1'b0, addr_rdata[infl_pkg::ADDR_W-1:0]};
    addr_raddr = num_idx;

    res_fire   = 1'b0;
    st_res     = infl_pkg::ST_OK;
    alloc_res  = '0;
    aout_res   = '0;
    marked_res = 1'b0;
    wvalid_res = 1'b0;
    waddr_res  = '0;
    wdata_res  = '0;

    app_en  = 1'b0;
    app_num = pidx;

    unique case (state)
      S_IDLE: begin
        pend_next = 1'b0;
        if (accept) begin
          case (op) inside
            infl_pkg::OP_FORMAT: begin
              head_next  = IW'(1);
              tail_next  = IW'(eff_count - infl_pkg::COUNT_W'(1));
              empty_next = 1'b0;
              if (eff_count == infl_pkg::COUNT_MIN) begin
                res_fire = 1'b1;
              end else begin
                scan_next  = IW'(1);
                state_next = S_FMT;
              end
            end
            infl_pkg::OP_RECOVERY_START: begin
              head_next      = '0;
              tail_next      = '0;
              empty_next     = 1'b1;
              scan_next      = '0;
              clr_reply_next = 1'b1;
              state_next     = S_CLEAR;
            end
            infl_pkg::OP_RECOVERY_END: begin
              scan_next  = IW'(1);
              state_next = S_REND;
            end
            infl_pkg::OP_ALLOCATE: begin
              if (empty) begin
                st_res   = infl_pkg::ST_EMPTY;
                res_fire = 1'b1;
              end else if (head == tail) begin
                alloc_res  = infl_pkg::NUM_W'(head);
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b1;
                res_fire   = 1'b1;
              end else begin
                state_next = S_ALLOC;
              end
            end
            infl_pkg::OP_RELEASE: begin
              res_fire = 1'b1;
              if (!in_range) begin
                st_res = infl_pkg::ST_RANGE;
              end else begin
                app_en  = 1'b1;
                app_num = num_idx;
              end
            end
            infl_pkg::OP_RECOVERY_MARK, infl_pkg::OP_SET_ADDRESS,
            infl_pkg::OP_GET_ADDRESS: begin
              if (!in_range) begin
                st_res   = infl_pkg::ST_RANGE;
                res_fire = 1'b1;
              end else begin
                state_next = S_AMEM;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // mark clearing pass: read entry, write it back unmarked once the read data is back
      S_CLEAR: begin
        addr_raddr = scan;
        pend_next  = 1'b1;
        pidx_next  = scan;
        if (pend) begin
          addr_we = 1'b1;
        end
        if (scan == LAST_IDX) begin
          state_next = S_CLRTAIL;
        end else begin
          scan_next = scan + IW'(1);
        end
      end

      S_CLRTAIL: begin
        addr_we        = 1'b1;
        pend_next      = 1'b0;
        res_fire       = clr_reply;
        clr_reply_next = 1'b0;
        state_next     = S_IDLE;
      end

      // format: chain links 1 -> 2 -> ... -> count-1
      S_FMT: begin
        link_we    = 1'b1;
        link_waddr = scan;
        link_wdata = scan + IW'(1);
        if (scan_w + WW'(2) == count_w) begin
          res_fire   = 1'b1;
          state_next = S_IDLE;
        end else begin
          scan_next = scan + IW'(1);
        end
      end

      // recovery end: read marks in order, append unmarked numbers
      S_REND: begin
        addr_raddr = scan;
        pend_next  = 1'b1;
        pidx_next  = scan;
        if (pend && !addr_rdata[MARK_BIT]) begin
          app_en = 1'b1;
        end
        if (scan_w + WW'(1) == count_w) begin
          state_next = S_RENDTAIL;
        end else begin
          scan_next = scan + IW'(1);
        end
      end

      S_RENDTAIL: begin
        if (pend && !addr_rdata[MARK_BIT]) begin
          app_en = 1'b1;
        end
        pend_next  = 1'b0;
        res_fire   = 1'b1;
        state_next = S_IDLE;
      end

      // allocate: link of the head is now read
      S_ALLOC: begin
        alloc_res  = infl_pkg::NUM_W'(head);
        head_next  = link_rdata;
        res_fire   = 1'b1;
        state_next = S_IDLE;
      end

      // mark, set and get address: entry is now read
      S_AMEM: begin
        addr_waddr = num_q;
        case (op_q)
          infl_pkg::OP_RECOVERY_MARK: begin
            if (addr_rdata[MARK_BIT]) begin
              marked_res = 1'b1;
            end else begin
              addr_we    = 1'b1;
              addr_wdata = {1'b1, aval_q};
            end
          end
          infl_pkg::OP_SET_ADDRESS: begin
            addr_we    = 1'b1;
            addr_wdata = {addr_rdata[MARK_BIT], aval_q};
            wvalid_res = 1'b1;
            waddr_res  = base_address + infl_pkg::ADDR_W'({number_q, 3'b000});
            wdata_res  = aval_q;
          end
          default: begin
            aout_res = addr_rdata[infl_pkg::ADDR_W-1:0];
          end
        endcase
        res_fire   = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // append to the tail of the list
    if (app_en) begin
      if (empty) begin
        head_next  = app_num;
        tail_next  = app_num;
        empty_next = 1'b0;
      end else begin
        link_we    = 1'b1;
        link_waddr = tail;
        link_wdata = app_num;
        tail_next  = app_num;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      scan         <= '0;
      pend         <= 1'b0;
      clr_reply    <= 1'b0;
      head         <= '0;
      tail         <= '0;
      empty        <= 1'b1;
      done         <= 1'b0;
      base_address <= '0;
      entry_count  <= infl_pkg::ENTRY_COUNT_RESET;
    end else begin
      state     <= state_next;
      scan      <= scan_next;
      pend      <= pend_next;
      clr_reply <= clr_reply_next;
      head      <= head_next;
      tail      <= tail_next;
      empty     <= empty_next;
      done      <= res_fire;
      if (cfg_write) begin
        case (cfg_index)
          infl_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data;
          infl_pkg::CFG_ENTRY_COUNT:  entry_count  <= cfg_data[infl_pkg::COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pidx <= pidx_next;
    if (accept) begin
      op_q     <= op;
      num_q    <= num_idx;
      number_q <= number;
      aval_q   <= address_value;
    end
    if (res_fire) begin
      status           <= st_res;
      allocated_number <= alloc_res;
      address_out      <= aout_res;
      already_marked   <= marked_res;
      write_valid      <= wvalid_res;
      write_address    <= waddr_res;
      write_data       <= wdata_res;
    end
  end

  // checks
  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    empty |-> (head == '0) && (tail == '0))
    else $error("empty list with nonzero head or tail");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clearing pass");

  a_amem_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_AMEM) |=> done)
    else $error("address operation gave no result");

  a_release_one: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == infl_pkg::OP_RELEASE)) |=> done && !busy)
    else $error("release did not finish in one cycle");

  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    (done && write_valid) |-> (status == infl_pkg::ST_OK) && !already_marked)
    else $error("external write with bad status");

endmodule : inode_number_free_list_core

`default_nettype wire
